>>> design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is applied.
`define ASSERT_IMP(lbl, clk, rst_n, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |-> (con)) \
		else $error("spis assertion failed");

// Next-cycle implication, switched off while reset is applied.
`define ASSERT_NEXT(lbl, clk, rst_n, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |=> (con)) \
		else $error("spis assertion failed");

`endif

>>> design/spis_pkg.sv
package spis_pkg;

	// Motor store and fixed-point scaling.
	localparam int MOTOR_COUNT        = 8;
	localparam int MOTOR_IDX_W        = $clog2(MOTOR_COUNT);
	localparam int GAIN_FRACTION_BITS = 8;
	localparam int DEADBAND           = 2;

	// Field widths.
	localparam int MOTOR_ID_W = 3;
	localparam int SPEED_W    = 16;
	localparam int GAIN_W     = 16;
	localparam int DRIVE_W    = 16;
	localparam int SEP_W      = 16;
	localparam int ILIM_W     = 23;
	localparam int OLIM_W     = 15;
	localparam int CFG_W      = 23;
	localparam int CFG_IDX_W  = 3;

	// Internal arithmetic widths.
	localparam int ERR_W    = SPEED_W + 1;
	localparam int INTEG_W  = ILIM_W + 1;
	localparam int DIFF_W   = ERR_W + 1;
	localparam int GAIN_S_W = GAIN_W + 1;
	localparam int PROD_P_W = GAIN_S_W + ERR_W;
	localparam int PROD_I_W = GAIN_S_W + INTEG_W;
	localparam int PROD_D_W = GAIN_S_W + DIFF_W;
	localparam int SUM_W    = PROD_I_W + 2;

	// Mode codes.
	localparam logic MODE_CHASSIS = 1'b0;
	localparam logic MODE_HANDLE  = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHASSIS_SEP  = 3'd0,
		REG_CHASSIS_ILIM = 3'd1,
		REG_CHASSIS_OLIM = 3'd2,
		REG_HANDLE_SEP   = 3'd3,
		REG_HANDLE_ILIM  = 3'd4,
		REG_HANDLE_OLIM  = 3'd5
	} cfg_reg_t;

	// Per-item quantities produced by the state stage.
	typedef struct packed {
		logic signed [ERR_W-1:0]   err;
		logic signed [INTEG_W-1:0] integ;
		logic signed [DIFF_W-1:0]  diff;
		logic                      in_deadband;
	} spis_terms_t;

endpackage

>>> design/spis_if.sv
// Input item channel.
interface spis_item_if;
	import spis_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [MOTOR_ID_W-1:0]       motor_index;
	logic                        mode;
	logic signed [SPEED_W-1:0]   speed_setpoint;
	logic signed [SPEED_W-1:0]   measured_speed;
	logic [GAIN_W-1:0]           gain_p;
	logic [GAIN_W-1:0]           gain_i;
	logic [GAIN_W-1:0]           gain_d;

	modport source (
		output valid, motor_index, mode, speed_setpoint, measured_speed,
		       gain_p, gain_i, gain_d,
		input  ready
	);
	modport sink (
		input  valid, motor_index, mode, speed_setpoint, measured_speed,
		       gain_p, gain_i, gain_d,
		output ready
	);
endinterface

// Result channel.
interface spis_result_if;
	import spis_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [MOTOR_ID_W-1:0]     motor_id;
	logic signed [DRIVE_W-1:0] drive_output;

	modport source (output valid, motor_id, drive_output, input ready);
	modport sink (input valid, motor_id, drive_output, output ready);
endinterface

>>> design/speed_pid_integral_separation_core.sv
// Per-motor speed PID with integral separation and anti-windup clamping. One item is
// accepted every clock cycle unless a held result stalls the pipeline. The stages are:
// an input register, a stage that reads and updates the motor's integral and last error
// and forms the three gain products, and a stage that scales, sums and saturates them
// into the result register. Motor state is updated as each item leaves the first stage,
// so consecutive items for the same motor see each other's updates without stalls.
// Ready passes back through every stage combinationally: a result held at the output
// stops the full stages behind it, and an item is still taken while an earlier result
// waits only as long as an empty stage remains. Configuration registers are written
// through cfg_we, cfg_index and cfg_data and must only be changed while no item is in
// flight.
module speed_pid_integral_separation_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [spis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spis_pkg::CFG_W-1:0]      cfg_data,
	spis_item_if.sink                       items,
	spis_result_if.source                   results
);
	import spis_pkg::*;

	// Configuration registers.
	logic [SEP_W-1:0]  chassis_sep_q;
	logic [ILIM_W-1:0] chassis_ilim_q;
	logic [OLIM_W-1:0] chassis_olim_q;
	logic [SEP_W-1:0]  handle_sep_q;
	logic [ILIM_W-1:0] handle_ilim_q;
	logic [OLIM_W-1:0] handle_olim_q;

	// Stage 1: registered input item.
	logic                      valid_s1;
	logic [MOTOR_ID_W-1:0]     motor_s1;
	logic                      mode_s1;
	logic signed [SPEED_W-1:0] target_s1;
	logic signed [SPEED_W-1:0] measured_s1;
	logic [GAIN_W-1:0]         gain_p_s1;
	logic [GAIN_W-1:0]         gain_i_s1;
	logic [GAIN_W-1:0]         gain_d_s1;

	// Stage 2: registered products.
	logic                       valid_s2;
	logic [MOTOR_ID_W-1:0]      motor_s2;
	logic                       mode_s2;
	logic                       deadband_s2;
	logic signed [PROD_P_W-1:0] prod_p_s2;
	logic signed [PROD_I_W-1:0] prod_i_s2;
	logic signed [PROD_D_W-1:0] prod_d_s2;

	// Result register.
	logic                      out_valid_q;
	logic [MOTOR_ID_W-1:0]     motor_id_q;
	logic signed [DRIVE_W-1:0] drive_q;

	logic                       ready_out;
	logic                       ready_s2;
	logic                       ready_s1;
	spis_terms_t                terms;
	logic signed [PROD_P_W-1:0] prod_p;
	logic signed [PROD_I_W-1:0] prod_i;
	logic signed [PROD_D_W-1:0] prod_d;
	logic signed [DRIVE_W-1:0]  drive;

	// Register writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chassis_sep_q  <= '0;
			chassis_ilim_q <= '0;
			chassis_olim_q <= '0;
			handle_sep_q   <= '0;
			handle_ilim_q  <= '0;
			handle_olim_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHASSIS_SEP:  chassis_sep_q  <= cfg_data[SEP_W-1:0];
				REG_CHASSIS_ILIM: chassis_ilim_q <= cfg_data[ILIM_W-1:0];
				REG_CHASSIS_OLIM: chassis_olim_q <= cfg_data[OLIM_W-1:0];
				REG_HANDLE_SEP:   handle_sep_q   <= cfg_data[SEP_W-1:0];
				REG_HANDLE_ILIM:  handle_ilim_q  <= cfg_data[ILIM_W-1:0];
				REG_HANDLE_OLIM:  handle_olim_q  <= cfg_data[OLIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Each stage moves on when the stage after it is empty or moving.
	assign ready_out    = !out_valid_q || results.ready;
	assign ready_s2     = !valid_s2 || ready_out;
	assign ready_s1     = !valid_s1 || ready_s2;
	assign items.ready  = ready_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && ready_s1) begin
			motor_s1    <= items.motor_index;
			mode_s1     <= items.mode;
			target_s1   <= items.speed_setpoint;
			measured_s1 <= items.measured_speed;
			gain_p_s1   <= items.gain_p;
			gain_i_s1   <= items.gain_i;
			gain_d_s1   <= items.gain_d;
		end
	end

	// Motor state lookup, integral separation and clamp.
	spis_state u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.motor_index    (motor_s1),
		.mode           (mode_s1),
		.speed_setpoint (target_s1),
		.measured_speed (measured_s1),
		.separation     ((mode_s1 == MODE_HANDLE) ? handle_sep_q : chassis_sep_q),
		.integral_limit ((mode_s1 == MODE_HANDLE) ? handle_ilim_q : chassis_ilim_q),
		.wr_en          (valid_s1 && ready_s2),
		.terms          (terms)
	);

	// Three independent gain products, unsigned gains widened to signed.
	assign prod_p = PROD_P_W'($signed({1'b0, gain_p_s1})) * PROD_P_W'(terms.err);
	assign prod_i = PROD_I_W'($signed({1'b0, gain_i_s1})) * PROD_I_W'(terms.integ);
	assign prod_d = PROD_D_W'($signed({1'b0, gain_d_s1})) * PROD_D_W'(terms.diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			motor_s2    <= motor_s1;
			mode_s2     <= mode_s1;
			deadband_s2 <= terms.in_deadband;
			prod_p_s2   <= prod_p;
			prod_i_s2   <= prod_i;
			prod_d_s2   <= prod_d;
		end
	end

	// Scale, sum and saturate.
	spis_sum u_sum (
		.mode         (mode_s2),
		.in_deadband  (deadband_s2),
		.prod_p       (prod_p_s2),
		.prod_i       (prod_i_s2),
		.prod_d       (prod_d_s2),
		.output_limit ((mode_s2 == MODE_HANDLE) ? handle_olim_q : chassis_olim_q),
		.drive        (drive)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_out) begin
			motor_id_q <= motor_s2;
			drive_q    <= drive;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.motor_id     = motor_id_q;
	assign results.drive_output = drive_q;

endmodule

>>> design/spis_state.sv
module spis_state (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [spis_pkg::MOTOR_ID_W-1:0]    motor_index,
	input  logic                               mode,
	input  logic signed [spis_pkg::SPEED_W-1:0] speed_setpoint,
	input  logic signed [spis_pkg::SPEED_W-1:0] measured_speed,
	input  logic [spis_pkg::SEP_W-1:0]         separation,
	input  logic [spis_pkg::ILIM_W-1:0]        integral_limit,
	input  logic                               wr_en,
	output spis_pkg::spis_terms_t              terms
);
	import spis_pkg::*;

	localparam int ACC_W = INTEG_W + 1;

	logic signed [INTEG_W-1:0] integ_q [MOTOR_COUNT];
	logic signed [ERR_W-1:0]   prev_q  [MOTOR_COUNT];

	logic                      idx_ok;
	logic [MOTOR_IDX_W-1:0]    idx;
	logic signed [INTEG_W-1:0] integ_rd;
	logic signed [ERR_W-1:0]   prev_rd;
	logic signed [ERR_W-1:0]   err;
	logic [ERR_W-1:0]          mag;
	logic                      integrate;
	logic signed [ACC_W-1:0]   acc;
	logic signed [ACC_W-1:0]   lim_s;
	logic signed [INTEG_W-1:0] integ_new;

	// Look up the motor's stored state; an index past the store reads as zero.
	assign idx_ok   = {1'b0, motor_index} < (MOTOR_ID_W + 1)'(MOTOR_COUNT);
	assign idx      = motor_index[MOTOR_IDX_W-1:0];
	assign integ_rd = idx_ok ? integ_q[idx] : '0;
	assign prev_rd  = idx_ok ? prev_q[idx] : '0;

	// Speed error and its magnitude.
	assign err = ERR_W'(speed_setpoint) - ERR_W'(measured_speed);
	assign mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

	// Integrate only inside the separation window, then clamp every time.
	assign integrate = mag <= ERR_W'(separation);
	assign acc       = ACC_W'(integ_rd) + (integrate ? ACC_W'(err) : ACC_W'(0));
	assign lim_s     = $signed(ACC_W'(integral_limit));

	always_comb begin
		if (acc > lim_s) begin
			integ_new = INTEG_W'(lim_s);
		end else if (acc < -lim_s) begin
			integ_new = INTEG_W'(-lim_s);
		end else begin
			integ_new = INTEG_W'(acc);
		end
	end

	assign terms.err         = err;
	assign terms.integ       = integ_new;
	assign terms.diff        = DIFF_W'(err) - DIFF_W'(prev_rd);
	assign terms.in_deadband = mag <= ERR_W'(DEADBAND);

	// Write back when the item leaves this stage; chassis mode leaves the last error alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				integ_q[i] <= '0;
				prev_q[i]  <= '0;
			end
		end else if (wr_en && idx_ok) begin
			integ_q[idx] <= integ_new;
			if (mode == MODE_HANDLE) begin
				prev_q[idx] <= err;
			end
		end
	end

endmodule

>>> design/spis_sum.sv
module spis_sum (
	input  logic                                 mode,
	input  logic                                 in_deadband,
	input  logic signed [spis_pkg::PROD_P_W-1:0] prod_p,
	input  logic signed [spis_pkg::PROD_I_W-1:0] prod_i,
	input  logic signed [spis_pkg::PROD_D_W-1:0] prod_d,
	input  logic [spis_pkg::OLIM_W-1:0]          output_limit,
	output logic signed [spis_pkg::DRIVE_W-1:0]  drive
);
	import spis_pkg::*;

	logic signed [SUM_W-1:0] term_p;
	logic signed [SUM_W-1:0] term_i;
	logic signed [SUM_W-1:0] term_d;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] lim_s;

	// Drop the gain fraction with an arithmetic shift, which rounds towards minus infinity.
	assign term_p = SUM_W'(prod_p >>> GAIN_FRACTION_BITS);
	assign term_i = SUM_W'(prod_i >>> GAIN_FRACTION_BITS);
	assign term_d = (mode == MODE_HANDLE) ? SUM_W'(prod_d >>> GAIN_FRACTION_BITS) : '0;

	assign sum   = term_p + term_i + term_d;
	assign lim_s = $signed(SUM_W'(output_limit));

	// Saturate symmetrically; the handle deadband forces zero.
	always_comb begin
		if (mode == MODE_HANDLE && in_deadband) begin
			drive = '0;
		end else if (sum > lim_s) begin
			drive = DRIVE_W'(lim_s);
		end else if (sum < -lim_s) begin
			drive = DRIVE_W'(-lim_s);
		end else begin
			drive = DRIVE_W'(sum);
		end
	end

endmodule

>>> design/spis_checker.sv
`include "assert_macros.svh"

module spis_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [spis_pkg::MOTOR_ID_W-1:0]     motor_id,
	input logic signed [spis_pkg::DRIVE_W-1:0] drive_output
);
	import spis_pkg::*;

	// A result held back by the sink keeps its value until the transfer.
	`ASSERT_NEXT(a_result_held, clk, arst_n, out_valid && !out_ready, out_valid && $stable(drive_output) && $stable(motor_id))

	// With the result side free, the pipeline always has room for a new item.
	`ASSERT_IMP(a_ready_when_drained, clk, arst_n, !out_valid || out_ready, in_ready)

	// Saturation is symmetric, so the most negative code never appears.
	`ASSERT_IMP(a_drive_symmetric, clk, arst_n, out_valid, drive_output != {1'b1, {(DRIVE_W-1){1'b0}}})

endmodule

bind speed_pid_integral_separation_core spis_checker u_spis_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (items.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.motor_id     (results.motor_id),
	.drive_output (results.drive_output)
);

>>> sim/spis_drive_checker.sv
// Watches the item and result channels of the speed PID core, keeps its own copy of the
// limit registers and of each motor's integral and last error, and compares every result
// transfer with the oldest predicted drive value.
module spis_drive_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [spis_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spis_pkg::CFG_W-1:0]     cfg_data,
	spis_item_if                           items,
	spis_result_if                         results,
	output int                             fail_count,
	output int                             pending,
	output int                             compared
);
	timeunit 1ns;
	timeprecision 1ps;
	import spis_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [MOTOR_ID_W-1:0]     motor_id;
		logic signed [DRIVE_W-1:0] drive;
	} drive_result_t;

	// Limit registers, indexed by mode.
	logic [SEP_W-1:0]  separation     [2];
	logic [ILIM_W-1:0] integral_limit [2];
	logic [OLIM_W-1:0] output_limit   [2];

	// Per-motor controller state.
	logic signed [INTEG_W-1:0] motor_integral   [MOTOR_COUNT];
	logic signed [ERR_W-1:0]   motor_last_error [MOTOR_COUNT];

	drive_result_t expected_drive_q [$];

	// One controller step for a motor: returns the drive value and updates the motor state.
	function automatic logic signed [DRIVE_W-1:0] advance_motor(
		input logic [MOTOR_ID_W-1:0]     motor,
		input logic                      mode,
		input logic signed [SPEED_W-1:0] target,
		input logic signed [SPEED_W-1:0] measured,
		input logic [GAIN_W-1:0]         kp,
		input logic [GAIN_W-1:0]         ki,
		input logic [GAIN_W-1:0]         kd
	);
		longint err, mag, integ, last, total, ilim, olim;
		integ = longint'(motor_integral[motor]);
		last  = longint'(motor_last_error[motor]);
		ilim  = longint'(integral_limit[mode]);
		olim  = longint'(output_limit[mode]);
		err   = longint'(target) - longint'(measured);
		mag   = (err < 0) ? -err : err;

		// Integral separation, then the clamp, which applies on every item.
		if (mag <= longint'(separation[mode]))
			integ = integ + err;
		if (integ > ilim)
			integ = ilim;
		else if (integ < -ilim)
			integ = -ilim;

		// Each product is scaled down with rounding towards minus infinity.
		total = ((longint'(kp) * err) >>> GAIN_FRACTION_BITS)
		      + ((longint'(ki) * integ) >>> GAIN_FRACTION_BITS);
		if (mode == MODE_HANDLE)
			total = total + ((longint'(kd) * (err - last)) >>> GAIN_FRACTION_BITS);

		if (total > olim)
			total = olim;
		else if (total < -olim)
			total = -olim;

		// Handle mode deadband forces the output to zero but keeps the state moving.
		if (mode == MODE_HANDLE && mag <= longint'(DEADBAND))
			total = '0;

		motor_integral[motor] = integ[INTEG_W-1:0];
		if (mode == MODE_HANDLE)
			motor_last_error[motor] = err[ERR_W-1:0];
		return total[DRIVE_W-1:0];
	endfunction

	// Register writes, result comparison and prediction on each accepted transfer.
	always @(posedge clk or negedge arst_n) begin
		drive_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				separation[i]     = '0;
				integral_limit[i] = '0;
				output_limit[i]   = '0;
			end
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				motor_integral[i]   = '0;
				motor_last_error[i] = '0;
			end
			expected_drive_q.delete();
			fail_count = 0;
			pending    = 0;
			compared   = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CHASSIS_SEP:  separation[MODE_CHASSIS]     = cfg_data[SEP_W-1:0];
					REG_CHASSIS_ILIM: integral_limit[MODE_CHASSIS] = cfg_data[ILIM_W-1:0];
					REG_CHASSIS_OLIM: output_limit[MODE_CHASSIS]   = cfg_data[OLIM_W-1:0];
					REG_HANDLE_SEP:   separation[MODE_HANDLE]      = cfg_data[SEP_W-1:0];
					REG_HANDLE_ILIM:  integral_limit[MODE_HANDLE]  = cfg_data[ILIM_W-1:0];
					REG_HANDLE_OLIM:  output_limit[MODE_HANDLE]    = cfg_data[OLIM_W-1:0];
					default: ;
				endcase
			end

			if (results.valid && results.ready) begin
				if (expected_drive_q.size() == 0) begin
					if (fail_count < REPORT_LIMIT)
						$display("unexpected result: motor_id %0d drive_output %0d",
							results.motor_id, results.drive_output);
					fail_count++;
				end else begin
					want = expected_drive_q.pop_front();
					compared++;
					if (results.motor_id !== want.motor_id ||
					    results.drive_output !== want.drive) begin
						if (fail_count < REPORT_LIMIT)
							$display("mismatch: expected %0d/%0d, got %0d/%0d",
								want.motor_id, want.drive,
								results.motor_id, results.drive_output);
						fail_count++;
					end
				end
			end

			if (items.valid && items.ready) begin
				want.motor_id = items.motor_index;
				want.drive    = advance_motor(items.motor_index, items.mode,
					items.speed_setpoint, items.measured_speed,
					items.gain_p, items.gain_i, items.gain_d);
				expected_drive_q.push_back(want);
			end

			pending = expected_drive_q.size();
		end
	end

endmodule

>>> sim/tb.sv
// Stimulus and verdict for the speed PID core. The checker beside the block predicts
// and compares every result transfer.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spis_pkg::*;

	localparam int RANDOM_PHASES    = 8;
	localparam int ITEMS_PER_PHASE  = 235;
	localparam int SETTLE_CYCLES    = 8;
	localparam int CYCLE_LIMIT      = 400000;

	typedef struct packed {
		logic [MOTOR_ID_W-1:0]     motor_index;
		logic                      mode;
		logic signed [SPEED_W-1:0] speed_setpoint;
		logic signed [SPEED_W-1:0] measured_speed;
		logic [GAIN_W-1:0]         gain_p;
		logic [GAIN_W-1:0]         gain_i;
		logic [GAIN_W-1:0]         gain_d;
	} speed_item_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 sink_ready = 1'b0;
	logic                 calm       = 1'b0;

	int fail_count, pending, compared;
	int items_sent    = 0;
	int settings_done = 1;
	int cycle_count   = 0;
	int stall_left    = 0;

	// Register images for the next write pass, and the separations for stimulus shaping.
	logic [CFG_W-1:0] cfg_vals [8];
	int               sep_now  [2];

	spis_item_if   item_ch ();
	spis_result_if result_ch ();

	assign result_ch.ready = sink_ready;

	speed_pid_integral_separation_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (item_ch),
		.results   (result_ch)
	);

	spis_drive_checker CHK (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.items      (item_ch),
		.results    (result_ch),
		.fail_count (fail_count),
		.pending    (pending),
		.compared   (compared)
	);

	always #4 clk = ~clk;

	// Cycle limit in case the block stops making transfers.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("cycle limit reached with %0d results outstanding", pending);
			$display("FAIL");
			$finish;
		end
	end

	// Result side: ready with random stall bursts, none in the calm stretch.
	always @(posedge clk) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
		end else if (calm) begin
			sink_ready <= 1'b1;
		end else if (stall_left > 0) begin
			sink_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			sink_ready <= 1'b1;
			if ($urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 8);
		end
	end

	function automatic speed_item_t mk(input int motor, input logic mode, input int target,
		input int measured, input int kp, input int ki, input int kd);
		speed_item_t it;
		it.motor_index    = MOTOR_ID_W'(motor);
		it.mode           = mode;
		it.speed_setpoint = SPEED_W'(target);
		it.measured_speed = SPEED_W'(measured);
		it.gain_p         = GAIN_W'(kp);
		it.gain_i         = GAIN_W'(ki);
		it.gain_d         = GAIN_W'(kd);
		return it;
	endfunction

	function automatic int pick_extreme_speed();
		case ($urandom_range(0, 2))
			0:       return -32768;
			1:       return 32767;
			default: return 0;
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] random_gain();
		case ($urandom_range(0, 9))
			6, 7, 8: return GAIN_W'($urandom_range(0, 511));
			9:       return ($urandom_range(0, 1) == 0) ? '0 : '1;
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	// Mostly errors around the separation threshold or the deadband, some wide noise.
	function automatic speed_item_t random_item();
		speed_item_t it;
		int emax, e, lo, hi, t, kind;
		it.motor_index = MOTOR_ID_W'($urandom_range(0, MOTOR_COUNT - 1));
		it.mode        = 1'($urandom_range(0, 1));
		kind           = $urandom_range(0, 9);
		if (kind < 3) begin
			it.speed_setpoint = SPEED_W'($urandom);
			it.measured_speed = SPEED_W'($urandom);
		end else if (kind < 9) begin
			emax = ($urandom_range(0, 3) == 0) ? 4 : sep_now[it.mode] + 3;
			if (emax > 65535)
				emax = 65535;
			e  = int'($urandom_range(2 * emax, 0)) - emax;
			lo = (e > 0) ? -32768 + e : -32768;
			hi = (e < 0) ? 32767 + e : 32767;
			t  = lo + int'($urandom_range(hi - lo, 0));
			it.speed_setpoint = SPEED_W'(t);
			it.measured_speed = SPEED_W'(t - e);
		end else begin
			it.speed_setpoint = SPEED_W'(pick_extreme_speed());
			it.measured_speed = SPEED_W'(pick_extreme_speed());
		end
		it.gain_p = random_gain();
		it.gain_i = random_gain();
		it.gain_d = random_gain();
		return it;
	endfunction

	function automatic logic [CFG_W-1:0] pick_limit(input int w);
		logic [CFG_W-1:0] mask;
		mask = (CFG_W'(1) << w) - 1'b1;
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return mask;
			2:       return CFG_W'($urandom_range(1, 40));
			3:       return CFG_W'($urandom_range(1, 5000)) & mask;
			default: return CFG_W'($urandom) & mask;
		endcase
	endfunction

	// Random bits above a register's width, which the block must drop.
	function automatic logic [CFG_W-1:0] junk_above(input int w);
		return CFG_W'($urandom) << w;
	endfunction

	task automatic send_item(input speed_item_t it);
		item_ch.valid          <= 1'b1;
		item_ch.motor_index    <= it.motor_index;
		item_ch.mode           <= it.mode;
		item_ch.speed_setpoint <= it.speed_setpoint;
		item_ch.measured_speed <= it.measured_speed;
		item_ch.gain_p         <= it.gain_p;
		item_ch.gain_i         <= it.gain_i;
		item_ch.gain_d         <= it.gain_d;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic pause_sender(input int cycles);
		item_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off the sender until every predicted result has made its transfer.
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all six limit registers plus the two unused indexes, one per cycle.
	task automatic set_limits(input logic [CFG_W-1:0] sep_c, input logic [CFG_W-1:0] ilim_c,
		input logic [CFG_W-1:0] olim_c, input logic [CFG_W-1:0] sep_h,
		input logic [CFG_W-1:0] ilim_h, input logic [CFG_W-1:0] olim_h);
		cfg_vals[REG_CHASSIS_SEP]  = sep_c  | junk_above(SEP_W);
		cfg_vals[REG_CHASSIS_ILIM] = ilim_c | junk_above(ILIM_W);
		cfg_vals[REG_CHASSIS_OLIM] = olim_c | junk_above(OLIM_W);
		cfg_vals[REG_HANDLE_SEP]   = sep_h  | junk_above(SEP_W);
		cfg_vals[REG_HANDLE_ILIM]  = ilim_h | junk_above(ILIM_W);
		cfg_vals[REG_HANDLE_OLIM]  = olim_h | junk_above(OLIM_W);
		cfg_vals[6] = CFG_W'($urandom);
		cfg_vals[7] = CFG_W'($urandom);
		sep_now[MODE_CHASSIS] = int'(sep_c[SEP_W-1:0]);
		sep_now[MODE_HANDLE]  = int'(sep_h[SEP_W-1:0]);
		for (int k = 0; k < 8; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(k);
			cfg_data  <= cfg_vals[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_done++;
	endtask

	initial begin
		item_ch.valid          = 1'b0;
		item_ch.motor_index    = '0;
		item_ch.mode           = MODE_CHASSIS;
		item_ch.speed_setpoint = '0;
		item_ch.measured_speed = '0;
		item_ch.gain_p         = '0;
		item_ch.gain_i         = '0;
		item_ch.gain_d         = '0;
		sep_now[MODE_CHASSIS]  = 0;
		sep_now[MODE_HANDLE]   = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset limits every integral and output is clamped to zero.
		send_item(mk(0, MODE_CHASSIS, 1000, 0, 65535, 65535, 65535));
		send_item(mk(7, MODE_HANDLE, -32768, 32767, 65535, 65535, 65535));
		drain();

		// Moderate limits: separation edges, deadband and full-scale errors.
		set_limits(100, 3000, 20000, 1000, 400000, 32767);
		send_item(mk(1, MODE_CHASSIS, 100, 0, 256, 256, 0));
		send_item(mk(1, MODE_CHASSIS, 0, -101, 256, 256, 0));
		send_item(mk(1, MODE_CHASSIS, -100, 0, 256, 256, 0));
		send_item(mk(2, MODE_CHASSIS, 32767, -32768, 65535, 65535, 65535));
		send_item(mk(2, MODE_CHASSIS, -32768, 32767, 65535, 65535, 65535));
		for (int e = 3; e >= -3; e--)
			send_item(mk(3, MODE_HANDLE, e, 0, 512, 128, 1024));
		send_item(mk(3, MODE_HANDLE, 1000, 0, 512, 128, 1024));
		send_item(mk(3, MODE_HANDLE, 0, 1001, 512, 128, 1024));
		send_item(mk(4, MODE_HANDLE, -32768, 32767, 65535, 65535, 65535));
		send_item(mk(4, MODE_HANDLE, 32767, -32768, 65535, 65535, 65535));
		send_item(mk(5, MODE_CHASSIS, 500, 0, 0, 0, 0));
		drain();

		// Largest limits everywhere.
		set_limits('1, '1, '1, '1, '1, '1);
		send_item(mk(0, MODE_CHASSIS, 32767, -32768, 65535, 65535, 0));
		send_item(mk(7, MODE_HANDLE, -32768, 32767, 65535, 65535, 65535));
		send_item(mk(7, MODE_HANDLE, 32767, -32768, 65535, 65535, 65535));
		send_item(mk(0, MODE_CHASSIS, -1, 0, 1, 0, 0));
		drain();

		// Random phases, each with fresh limits; the last one runs without idling.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_limits(pick_limit(SEP_W), pick_limit(ILIM_W), pick_limit(OLIM_W),
				pick_limit(SEP_W), pick_limit(ILIM_W), pick_limit(OLIM_W));
			if (p == RANDOM_PHASES - 1)
				calm <= 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_item(random_item());
				if (p != RANDOM_PHASES - 1 && $urandom_range(0, 5) == 0)
					pause_sender($urandom_range(1, 8));
			end
			drain();
		end

		$display("Sent %0d items under %0d limit settings, reset, extreme and random.",
			items_sent, settings_done);
		$display("Compared %0d results across both modes, all motors and both stall sides.",
			compared);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
